// ----- rtl/psae_pkg.sv -----
// ============================================================================
// psae_pkg
// Shared types, constants and helpers for the active/expired priority
// scheduler.
// ============================================================================
package psae_pkg;

   // Sizing of the scheduler.
   localparam int MAX_LEVELS = 4;
   localparam int MAX_TASKS  = 16;
   localparam int NQUEUES    = 2 * MAX_LEVELS;
   localparam int MEM_DEPTH  = NQUEUES * MAX_TASKS;

   // Derived widths.
   localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int QIDX_W = $clog2(NQUEUES);
   localparam int PTR_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int TOT_W  = $clog2(MAX_LEVELS * MAX_TASKS + 1);
   localparam int ADDR_W = $clog2(MEM_DEPTH);
   // Wide enough to compare the priority fields with the level limits.
   localparam int CMP_W  = ((LVL_W > 3) ? LVL_W : 3) + 1;

   // Fixed field widths of the item formats.
   localparam int TID_W   = 4;
   localparam int BASE_W  = 3;
   localparam int CUR_W   = 2;
   localparam int NEWP_W  = 2;
   localparam int STAT_W  = 2;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 16;

   // Item kinds carried in tuser.
   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TAKE = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_READ,
      ST_DONE
   } psae_state_type;

   // Queue number of one level in one physical bank.
   function automatic logic [QIDX_W-1:0] qidx(input logic bank,
                                               input logic [LVL_W-1:0] lv);
      return QIDX_W'(bank ? (MAX_LEVELS + int'(lv)) : int'(lv));
   endfunction

   // Address of one slot of one queue in the shared queue memory.
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [QIDX_W-1:0] q,
                                                    input logic [PTR_W-1:0] ptr);
      return ADDR_W'(int'(q) * MAX_TASKS + int'(ptr));
   endfunction

endpackage

// ----- rtl/priority_scheduler_active_expired.sv -----
// ============================================================================
// priority_scheduler_active_expired
// Multilevel ready-queue scheduler with an active and an expired bank of FIFO
// queues, one queue per priority level in each bank.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ----------------------------------
//  req_      in         req_tvalid/tready    tuser: mode; tdata: task, priorities
//  rsp_      out        rsp_tvalid/tready    tdata: status, task, level, flags
//
//  An add item passes through the add and done steps before the next item is
//  accepted; a take item passes through a scan, in which the single count
//  comparator walks the levels from the top down to the first non-empty queue,
//  then the read and done steps, or straight to done when nothing is ready.
//  The pace is set by the level walk and the one read port of the queue memory.
//  Reset is synchronous and active high; it empties every queue by clearing
//  the read pointers, fill counts and totals. The queue memory is not cleared.
//  A result waits in the output register while the downstream side stalls;
//  the next item is still accepted meanwhile, and its result is held back in
//  the final step until the output register is free.
//
module priority_scheduler_active_expired (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [0] mode
   input  logic                        req_tuser,
   // [3:0] task_id, [6:4] base_priority, [8:7] current_priority,
   // [9] was_preempted, [15:10] zero
   input  logic [psae_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [1:0] status, [5:2] chosen_task, [7:6] new_priority, [8] went_expired,
   // [9] banks_swapped, [15:10] zero
   output logic [psae_pkg::RSP_W-1:0]  rsp_tdata
);
   import psae_pkg::*;

   // Sequencer state.
   psae_state_type                state_ff, state_in;

   // Scheduler state: one read pointer and fill count per queue.
   logic [PTR_W-1:0]              heads_ff  [NQUEUES];
   logic [PTR_W-1:0]              heads_in  [NQUEUES];
   logic [CNT_W-1:0]              counts_ff [NQUEUES];
   logic [CNT_W-1:0]              counts_in [NQUEUES];
   logic                          active_bank_ff, active_bank_in;
   logic [TOT_W-1:0]              active_total_ff, active_total_in;
   logic [TOT_W-1:0]              expired_total_ff, expired_total_in;

   // Working registers of the item in flight.
   logic [TID_W-1:0]              tid_ff, tid_in;
   logic [LVL_W-1:0]              level_ff, level_in;
   logic                          bank_ff, bank_in;
   logic [LVL_W-1:0]              lv_ff, lv_in;

   // Result being assembled.
   logic [STAT_W-1:0]             res_status_ff, res_status_in;
   logic [TID_W-1:0]              res_chosen_ff, res_chosen_in;
   logic                          res_expd_ff, res_expd_in;
   logic                          res_swp_ff, res_swp_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]              rsp_data_ff, rsp_data_in;

   // Queue memory port.
   logic [TID_W-1:0]              queue_mem [MEM_DEPTH];
   logic                          mem_we;
   logic                          mem_re;
   logic [ADDR_W-1:0]             mem_addr;
   logic [TID_W-1:0]              mem_wdata;
   logic [TID_W-1:0]              rd_data_ff;

   // Unpacked input fields.
   logic                          in_mode;
   logic [TID_W-1:0]              in_tid;
   logic [BASE_W-1:0]             in_base;
   logic [CUR_W-1:0]              in_cur;
   logic                          in_pre;

   assign in_mode = req_tuser;
   assign in_tid  = req_tdata[TID_W-1:0];
   assign in_base = req_tdata[TID_W +: BASE_W];
   assign in_cur  = req_tdata[TID_W+BASE_W +: CUR_W];
   assign in_pre  = req_tdata[TID_W+BASE_W+CUR_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      logic [CMP_W-1:0]   base_ext;
      logic [CMP_W-1:0]   cur_ext;
      logic [CMP_W-1:0]   lvl_calc;
      logic               expd;
      logic [QIDX_W-1:0]  q;
      logic [CNT_W-1:0]   cnt;
      logic [PTR_W-1:0]   head;
      logic [CNT_W:0]     tail_sum;
      logic [PTR_W-1:0]   tail;

      state_in         = state_ff;
      heads_in         = heads_ff;
      counts_in        = counts_ff;
      active_bank_in   = active_bank_ff;
      active_total_in  = active_total_ff;
      expired_total_in = expired_total_ff;
      tid_in           = tid_ff;
      level_in         = level_ff;
      bank_in          = bank_ff;
      lv_in            = lv_ff;
      res_status_in    = res_status_ff;
      res_chosen_in    = res_chosen_ff;
      res_expd_in      = res_expd_ff;
      res_swp_in       = res_swp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      mem_addr         = '0;
      mem_wdata        = tid_ff;

      // Saturate the priorities into range and work out the target level.
      base_ext = CMP_W'(in_base);
      if (base_ext < CMP_W'(1)) begin
         base_ext = CMP_W'(1);
      end else if (base_ext > CMP_W'(MAX_LEVELS)) begin
         base_ext = CMP_W'(MAX_LEVELS);
      end
      cur_ext = CMP_W'(in_cur);
      if (cur_ext > CMP_W'(MAX_LEVELS - 1)) begin
         cur_ext = CMP_W'(MAX_LEVELS - 1);
      end
      expd = in_pre && (cur_ext == '0);
      if (expd) begin
         lvl_calc = base_ext - CMP_W'(1);
      end else begin
         lvl_calc = cur_ext - CMP_W'(in_pre);
      end

      // One queue is looked at per cycle; its number depends on the step.
      if (state_ff == ST_ADD) begin
         q = qidx(bank_ff, level_ff);
      end else begin
         q = qidx(active_bank_ff, lv_ff);
      end
      cnt  = counts_ff[q];
      head = heads_ff[q];

      tail_sum = (CNT_W+1)'(head) + (CNT_W+1)'(cnt);
      if (tail_sum >= (CNT_W+1)'(MAX_TASKS)) begin
         tail = PTR_W'(tail_sum - (CNT_W+1)'(MAX_TASKS));
      end else begin
         tail = PTR_W'(tail_sum);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               tid_in        = in_tid;
               level_in      = LVL_W'(lvl_calc);
               bank_in       = active_bank_ff ^ expd;
               res_status_in = STATUS_DONE;
               res_chosen_in = '0;
               lv_in         = LVL_W'(MAX_LEVELS - 1);
               if (in_mode == MODE_ADD) begin
                  res_expd_in = expd;
                  res_swp_in  = 1'b0;
                  state_in    = ST_ADD;
               end else begin
                  // A take item reports no level; the banks swap when the
                  // active bank has run dry, even if both are empty.
                  level_in    = '0;
                  res_expd_in = 1'b0;
                  res_swp_in  = (active_total_ff == '0);
                  if (active_total_ff == '0) begin
                     active_total_in  = expired_total_ff;
                     expired_total_in = '0;
                     active_bank_in   = !active_bank_ff;
                  end
                  state_in = ST_SCAN;
               end
            end
         end
         ST_ADD: begin
            if (cnt >= CNT_W'(MAX_TASKS)) begin
               res_status_in = STATUS_FULL;
            end else begin
               mem_we       = 1'b1;
               mem_addr     = slot_addr(q, tail);
               counts_in[q] = cnt + CNT_W'(1);
               if (res_expd_ff) begin
                  expired_total_in = expired_total_ff + TOT_W'(1);
               end else begin
                  active_total_in = active_total_ff + TOT_W'(1);
               end
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (cnt != '0) begin
               mem_re       = 1'b1;
               mem_addr     = slot_addr(q, head);
               counts_in[q] = cnt - CNT_W'(1);
               if (head == PTR_W'(MAX_TASKS - 1)) begin
                  heads_in[q] = '0;
               end else begin
                  heads_in[q] = head + PTR_W'(1);
               end
               if (active_total_ff != '0) begin
                  active_total_in = active_total_ff - TOT_W'(1);
               end
               state_in = ST_READ;
            end else if (lv_ff == '0) begin
               res_status_in = STATUS_EMPTY;
               state_in      = ST_DONE;
            end else begin
               lv_in = lv_ff - LVL_W'(1);
            end
         end
         ST_READ: begin
            res_chosen_in = rd_data_ff;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({res_swp_ff, res_expd_ff, NEWP_W'(level_ff),
                                      res_chosen_ff, res_status_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         active_bank_ff   <= 1'b0;
         active_total_ff  <= '0;
         expired_total_ff <= '0;
         for (int i = 0; i < NQUEUES; i++) begin
            heads_ff[i]  <= '0;
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         active_bank_ff   <= active_bank_in;
         active_total_ff  <= active_total_in;
         expired_total_ff <= expired_total_in;
         heads_ff         <= heads_in;
         counts_ff        <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff        <= tid_in;
      level_ff      <= level_in;
      bank_ff       <= bank_in;
      lv_ff         <= lv_in;
      res_status_ff <= res_status_in;
      res_chosen_ff <= res_chosen_in;
      res_expd_ff   <= res_expd_in;
      res_swp_ff    <= res_swp_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Queue memory: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= queue_mem[mem_addr];
      end
   end

endmodule

// ----- rtl/psae_checker.sv -----
// ============================================================================
// psae_checker
// Port-level checks for the active/expired priority scheduler.
// ============================================================================
module psae_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [psae_pkg::RSP_W-1:0]  rsp_tdata
);
   import psae_pkg::*;

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The block does not take an item in the cycle after it has taken one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted on consecutive cycles");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == STATUS_DONE || rsp_tdata[1:0] == STATUS_EMPTY ||
                      rsp_tdata[1:0] == STATUS_FULL))
      else $error("undefined status code");

   // Nothing ready means no task is reported.
   a_empty_no_task: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == STATUS_EMPTY |-> rsp_tdata[5:2] == '0)
      else $error("task reported with nothing ready");

   // A swap comes from a take item, which reports no level and no expiry.
   a_swap_is_take: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[8:6] == '0)
      else $error("swap reported with add-item fields");

endmodule

bind priority_scheduler_active_expired psae_checker u_psae_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the active/expired priority scheduler
// Drives add and take items into the request stream, keeps its own model of
// both queue banks, and checks every result item field by field, while both
// sides of the block idle and stall at random.
// ----------------------------------------------------------------------------

import psae_pkg::*;

// One expected result item, one member per field of rsp_tdata.
typedef struct {
   logic [STAT_W-1:0] status;
   logic [TID_W-1:0]  chosen_task;
   logic [NEWP_W-1:0] new_priority;
   logic              went_expired;
   logic              banks_swapped;
} sched_result_type;

// Keeps its own copy of both banks, predicts the result of each accepted
// request item and checks the result items in order against those predictions.
class ready_queue_scoreboard;
   // Only a handful of items can be in flight inside the block at once.
   localparam int PENDING_DEPTH = 16;

   sched_result_type pending_results [PENDING_DEPTH];
   int unsigned      pending_rd;
   int unsigned      pending_wr;
   int unsigned      pending_count;
   int               errors;
   logic [TID_W-1:0] slots [NQUEUES][MAX_TASKS];
   int unsigned      head [NQUEUES];
   int unsigned      fill [NQUEUES];
   bit               live_bank;
   int unsigned      live_total;
   int unsigned      spent_total;

   function new();
      errors = 0;
      pending_rd = 0;
      pending_wr = 0;
      pending_count = 0;
      live_bank = 1'b0;
      live_total = 0;
      spent_total = 0;
      foreach (head[q]) begin
         head[q] = 0;
         fill[q] = 0;
      end
   endfunction

   // Works out the result of one item and updates the banks accordingly.
   function sched_result_type schedule_item(logic mode, logic [REQ_W-1:0] data);
      sched_result_type r;
      int            base;
      int            cur;
      int            lvl;
      int            q;
      bit            bank;
      r = '{STATUS_DONE, '0, '0, 1'b0, 1'b0};
      if (mode == MODE_ADD) begin
         base = int'(data[6:4]);
         cur  = int'(data[8:7]);
         if (base < 1) base = 1;
         if (base > MAX_LEVELS) base = MAX_LEVELS;
         if (cur > MAX_LEVELS - 1) cur = MAX_LEVELS - 1;
         lvl = cur - int'(data[9]);
         bank = live_bank;
         if (lvl < 0) begin
            // The task has used up its slice: it goes to the other bank
            // with its level refreshed from the static priority.
            lvl = base - 1;
            r.went_expired = 1'b1;
            bank = ~live_bank;
         end
         r.new_priority = NEWP_W'(lvl);
         q = int'(bank) * MAX_LEVELS + lvl;
         if (fill[q] >= MAX_TASKS) begin
            r.status = STATUS_FULL;
         end else begin
            slots[q][(head[q] + fill[q]) % MAX_TASKS] = data[3:0];
            fill[q]++;
            if (r.went_expired) spent_total++;
            else live_total++;
         end
      end else begin
         if (live_total == 0) begin
            live_total = spent_total;
            spent_total = 0;
            live_bank = ~live_bank;
            r.banks_swapped = 1'b1;
         end
         r.status = STATUS_EMPTY;
         for (lvl = MAX_LEVELS - 1; lvl >= 0; lvl--) begin
            q = int'(live_bank) * MAX_LEVELS + lvl;
            if (fill[q] != 0) begin
               r.status = STATUS_DONE;
               r.chosen_task = slots[q][head[q]];
               head[q] = (head[q] + 1) % MAX_TASKS;
               fill[q]--;
               if (live_total > 0) live_total--;
               break;
            end
         end
      end
      return r;
   endfunction

   // Number of results still expected from the block.
   function int unsigned outstanding();
      return pending_count;
   endfunction

   task note_request(logic mode, logic [REQ_W-1:0] data);
      if (pending_count == PENDING_DEPTH) begin
         report("more request items in flight than the block can hold");
         return;
      end
      pending_results[pending_wr] = schedule_item(mode, data);
      pending_wr = (pending_wr + 1) % PENDING_DEPTH;
      pending_count++;
   endtask

   task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
   endtask

   task check_result(logic [RSP_W-1:0] data);
      sched_result_type e;
      if (pending_count == 0) begin
         report($sformatf("result item 0x%04h with none expected", data));
         return;
      end
      e = pending_results[pending_rd];
      pending_rd = (pending_rd + 1) % PENDING_DEPTH;
      pending_count--;
      if (data[1:0] !== e.status)
         report($sformatf("status %0d, expected %0d", data[1:0], e.status));
      if (data[5:2] !== e.chosen_task)
         report($sformatf("chosen_task %0d, expected %0d", data[5:2], e.chosen_task));
      if (data[7:6] !== e.new_priority)
         report($sformatf("new_priority %0d, expected %0d", data[7:6], e.new_priority));
      if (data[8] !== e.went_expired)
         report($sformatf("went_expired %b, expected %b", data[8], e.went_expired));
      if (data[9] !== e.banks_swapped)
         report($sformatf("banks_swapped %b, expected %b", data[9], e.banks_swapped));
   endtask
endclass

module tb;

   // The settling time at the end allows several times over for the slowest
   // item, a take that finds its task only at the lowest level.
   localparam int SETTLE_CYCLES = 4 * (3 + MAX_LEVELS);
   // Far beyond the slowest correct run of about a thousand items, each of
   // which may wait out long sender gaps, receiver stalls and a full scan.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 950;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic              req_tuser  = MODE_ADD;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   // Percentages of cycles in which each side holds back.
   int unsigned       sender_idle_pct   = 15;
   int unsigned       receiver_idle_pct = 61;
   int unsigned       cycle_count       = 0;

   ready_queue_scoreboard ledger = new();

   priority_scheduler_active_expired DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Both handshakes are observed at the rising edge, before the block's own
   // registers move, so the values seen are the ones that were accepted.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_tvalid && req_tready)
         ledger.note_request(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_result(rsp_tdata);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // The receiver decides afresh at every falling edge whether it will take
   // a result item at the next rising edge.
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= receiver_idle_pct);
   end

   // Offers one item and returns just after the edge at which it was taken.
   // Random idle cycles go in front of it; valid stays high between items
   // that follow each other without a gap.
   task send_item(logic mode, logic [TID_W-1:0] tid, logic [BASE_W-1:0] base,
                  logic [CUR_W-1:0] cur, logic preempted);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {6'b0, preempted, cur, base, tid};
      do @(posedge clock); while (!req_tready);
   endtask

   task add_task(logic [TID_W-1:0] tid, logic [BASE_W-1:0] base,
                 logic [CUR_W-1:0] cur, logic preempted);
      send_item(MODE_ADD, tid, base, cur, preempted);
   endtask

   task take_task();
      // The payload of a take item is ignored, so it carries random bits.
      send_item(MODE_TAKE, 4'($urandom), 3'($urandom), 2'($urandom), 1'($urandom));
   endtask

   // Holds the request side quiet until every expected result has come back.
   task drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
   endtask

   // A random item. The share of adds is shifted by the caller in long
   // stretches, so that the queues fill right up at times and run dry at
   // others, which brings out full queues, empty takes and bank swaps.
   task random_item(int unsigned add_pct);
      logic [BASE_W-1:0] base;
      if ($urandom_range(99) < add_pct) begin
         // Mostly legal static priorities, sometimes values to be saturated.
         if ($urandom_range(9) == 0) base = 3'($urandom);
         else base = 3'($urandom_range(MAX_LEVELS, 1));
         add_task(4'($urandom), base, 2'($urandom), ($urandom_range(2) == 0));
      end else begin
         take_task();
      end
   endtask

   initial begin
      int unsigned add_pct;
      int          phase;
      int          n;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. A take on an empty scheduler swaps the banks and finds
      // nothing; preempted tasks at level zero go to the expired bank with
      // their static priority saturated from both ends.
      take_task();
      add_task(4'd0, 3'd0, 2'd0, 1'b1);
      add_task(4'd15, 3'd7, 2'd0, 1'b1);
      add_task(4'd5, 3'd4, 2'd3, 1'b1);
      add_task(4'd10, 3'd1, 2'd0, 1'b0);
      // Two takes from the active bank, then two that find the expired tasks,
      // highest level first, the first of them after it has swapped the banks.
      take_task();
      take_task();
      take_task();
      take_task();
      // Both banks are empty again: the banks swap and nothing is ready.
      take_task();
      // Fill the top level until it overflows; the last add is dropped.
      for (n = 0; n <= MAX_TASKS; n++)
         add_task(4'(n), 3'($urandom_range(MAX_LEVELS, 1)), 2'd3, 1'b0);
      take_task();

      // Random part, in three stretches of different idling.
      for (phase = 0; phase < 3; phase++) begin
         drain_results();
         case (phase)
            0: begin
               sender_idle_pct = 15;
               receiver_idle_pct = 61;
            end
            1: begin
               sender_idle_pct = 61;
               receiver_idle_pct = 15;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         add_pct = 55;
         for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
            if (n % 60 == 0) begin
               case ($urandom_range(2))
                  0: add_pct = 85;
                  1: add_pct = 30;
                  default: add_pct = 55;
               endcase
            end
            if ($urandom_range(49) == 0) drain_results();
            random_item(add_pct);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/psae_pkg.sv
rtl/priority_scheduler_active_expired.sv
rtl/psae_checker.sv
test/tb.sv
